// ----- design/csr_sparse_matrix_vector_multiply_assert.svh -----
// ----------------------------------------------------------------------------
// spmv assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS

// check with reset as the disable condition
`define SPMV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spmv check failed");

// check that also holds across reset
`define SPMV_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("spmv check failed");

`else

`define SPMV_ASSERT(lbl, clk, rst, prop)
`define SPMV_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- design/spmv_pkg.sv -----
// ----------------------------------------------------------------------------
// spmv package
// widths, mode codes and shared types of the csr spmv block
// ----------------------------------------------------------------------------
package spmv_pkg;

   localparam int INDEX_W      = 12;
   localparam int VALUE_W      = 32;
   localparam int ROW_W        = 16;
   localparam int SUM_W        = 64;
   // store depth covers every index code; row counter wraps at 2**ROW_W rows
   localparam int VECTOR_DEPTH = 4096;

   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_NONZERO = 2'd1;
   localparam logic [1:0] MODE_EMPTY   = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // per-word control that travels down the mac pipeline
   typedef struct packed {
      logic mul;    // multiply by the stored vector element
      logic acc;    // word touches the accumulator
      logic close;  // word ends the row
   } spmv_op_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row_index;
      logic signed [SUM_W-1:0] row_sum;
      logic                    saturated;
   } spmv_result_type;

endpackage

// ----- design/spmv_if.sv -----
// ----------------------------------------------------------------------------
// spmv channel interfaces
// valid/ready channels for request words and row results
// ----------------------------------------------------------------------------
interface spmv_req_if;
   import spmv_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic [INDEX_W-1:0]        index;
   logic signed [VALUE_W-1:0] value;
   logic                      last_in_row;

   modport source (output valid, mode, index, value, last_in_row, input ready);
   modport sink   (input valid, mode, index, value, last_in_row, output ready);
endinterface

interface spmv_rsp_if;
   import spmv_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        row_index;
   logic signed [SUM_W-1:0] row_sum;
   logic                    saturated;

   modport source (output valid, row_index, row_sum, saturated, input ready);
   modport sink   (input valid, row_index, row_sum, saturated, output ready);
endinterface

// ----- design/spmv_vec_store.sv -----
// ----------------------------------------------------------------------------
// spmv vector store
// single-port dense vector memory with registered read data
// ----------------------------------------------------------------------------
module spmv_vec_store (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic                              rd_en,
   input  logic [spmv_pkg::INDEX_W-1:0]      addr,
   input  logic signed [spmv_pkg::VALUE_W-1:0] wr_data,
   output logic signed [spmv_pkg::VALUE_W-1:0] rd_data
);
   import spmv_pkg::*;

   logic signed [VALUE_W-1:0] vec_mem [VECTOR_DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vec_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vec_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/spmv_mac.sv -----
// ----------------------------------------------------------------------------
// spmv multiply-accumulate
// product stage, saturating row accumulator and result register
// ----------------------------------------------------------------------------
module spmv_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pipe_en,
   input  spmv_pkg::spmv_op_type               op_in,
   input  logic signed [spmv_pkg::VALUE_W-1:0] value_in,
   input  logic signed [spmv_pkg::VALUE_W-1:0] vec_rd_data,
   output logic                                res_valid,
   output spmv_pkg::spmv_result_type           res
);
   import spmv_pkg::*;

   spmv_op_type               s1_op_ff, s1_op_in;
   logic signed [VALUE_W-1:0] s1_value_ff, s1_value_in;
   spmv_op_type               s2_op_ff, s2_op_in;
   logic signed [SUM_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic                      ovf_ff, ovf_in;
   logic [ROW_W-1:0]          row_cnt_ff, row_cnt_in;
   logic                      res_valid_ff, res_valid_in;
   spmv_result_type           res_ff, res_in;

   logic signed [SUM_W-1:0]   mul_full;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   acc_new;
   logic                      sat_now;
   logic                      ovf_new;

   // exact q32.32 product of two q16.16 values
   assign mul_full = SUM_W'(s1_value_ff) * SUM_W'(vec_rd_data);

   always_comb begin
      s1_op_in    = pipe_en ? op_in : s1_op_ff;
      s1_value_in = pipe_en ? value_in : s1_value_ff;
      s2_op_in    = pipe_en ? s1_op_ff : s2_op_ff;
      prod_in     = prod_ff;
      if (pipe_en) begin
         prod_in = s1_op_ff.mul ? mul_full : '0;
      end
   end

   // signed add with clamp to the 64-bit range
   always_comb begin
      sum     = acc_ff + prod_ff;
      sat_now = (acc_ff[SUM_W-1] == prod_ff[SUM_W-1]) && (sum[SUM_W-1] != acc_ff[SUM_W-1]);
      acc_new = sat_now ? (acc_ff[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;
      ovf_new = ovf_ff | sat_now;
   end

   always_comb begin
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      row_cnt_in   = row_cnt_ff;
      res_valid_in = res_valid_ff;
      res_in       = res_ff;
      if (pipe_en) begin
         res_valid_in = 1'b0;
         if (s2_op_ff.acc) begin
            if (s2_op_ff.close) begin
               res_valid_in     = 1'b1;
               res_in.row_index = row_cnt_ff;
               res_in.row_sum   = acc_new;
               res_in.saturated = ovf_new;
               acc_in           = '0;
               ovf_in           = 1'b0;
               row_cnt_in       = row_cnt_ff + ROW_W'(1);
            end else begin
               acc_in = acc_new;
               ovf_in = ovf_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff     <= '0;
         s2_op_ff     <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         row_cnt_ff   <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_op_ff     <= s1_op_in;
         s2_op_ff     <= s2_op_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         row_cnt_ff   <= row_cnt_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff <= s1_value_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

// ----- design/csr_sparse_matrix_vector_multiply.sv -----
// ----------------------------------------------------------------------------
// csr sparse matrix times dense vector
// streams csr nonzeros against a stored q16.16 vector, emits one q32.32 row sum
// ----------------------------------------------------------------------------
// usage
//   req_chan takes one word per cycle: mode 0 loads a vector element at index,
//   mode 1 is a nonzero (column index, value), last_in_row closes the row,
//   mode 2 closes the current row without a term of its own; mode 3 does nothing
//   rsp_chan gives one word per closed row: row index, saturating sum and a
//   flag that is set if any add of the row clamped
//   throughput is one request word per cycle while rsp is not stalled,
//   nonzeros back to back; a load may be followed by a nonzero of the same
//   index in the next cycle; a closing word reaches rsp valid through the
//   vector store read, multiply register and accumulate into result register
//   reset clears the accumulator, the saturation flag, the row counter and
//   all pipeline valids; vector store contents are undefined until loaded
//   when rsp holds a word that is not taken, the whole pipeline freezes and
//   req ready drops in the same cycle; ready returns as soon as rsp is taken
// ----------------------------------------------------------------------------
`include "csr_sparse_matrix_vector_multiply_assert.svh"

module csr_sparse_matrix_vector_multiply (
   input logic       clock,
   input logic       reset,
   spmv_req_if.sink  req_chan,
   spmv_rsp_if.source rsp_chan
);
   import spmv_pkg::*;

   logic            pipe_en;   // pipeline advances this cycle
   logic            accept;    // request word taken at this edge
   logic            vec_wr_en;
   spmv_op_type     op;
   logic signed [VALUE_W-1:0] vec_rd_data;
   logic            res_valid;
   spmv_result_type res;

   // the only stall source is an untaken result in the output register
   assign pipe_en        = !res_valid || rsp_chan.ready;
   assign req_chan.ready = pipe_en;
   assign accept         = req_chan.valid && pipe_en;

   // decode the mode into pipeline control, all zero for bubbles
   always_comb begin
      op        = '0;
      vec_wr_en = 1'b0;
      if (accept) begin
         unique case (req_chan.mode)
            MODE_LOAD: begin
               vec_wr_en = 1'b1;
            end
            MODE_NONZERO: begin
               op.mul   = 1'b1;
               op.acc   = 1'b1;
               op.close = req_chan.last_in_row;
            end
            MODE_EMPTY: begin
               // adds zero, then closes with whatever the accumulator holds
               op.acc   = 1'b1;
               op.close = 1'b1;
            end
            default: begin
               op = '0;
            end
         endcase
      end
   end

   // vector store: load writes at accept, nonzero reads land next cycle
   spmv_vec_store u_vec_store (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .rd_en   (op.mul),
      .addr    (req_chan.index),
      .wr_data (req_chan.value),
      .rd_data (vec_rd_data)
   );

   // multiply, saturating accumulate and output register
   spmv_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .pipe_en     (pipe_en),
      .op_in       (op),
      .value_in    (req_chan.value),
      .vec_rd_data (vec_rd_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   assign rsp_chan.valid     = res_valid;
   assign rsp_chan.row_index = res.row_index;
   assign rsp_chan.row_sum   = res.row_sum;
   assign rsp_chan.saturated = res.saturated;

   // a result that follows a taken one directly is always the next row
   `SPMV_ASSERT(a_rows_in_order, clock, reset, (rsp_chan.valid && rsp_chan.ready) |=> (!rsp_chan.valid || ((rsp_chan.row_index - $past(rsp_chan.row_index)) == 16'd1)))
   // no result survives a reset
   `SPMV_ASSERT_ALWAYS(a_reset_flushes, clock, reset |=> !rsp_chan.valid)
   // requests are refused only while a result waits on the output
   `SPMV_ASSERT(a_stall_cause, clock, reset, !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))

endmodule

// ----- sim/csr_sparse_matrix_vector_multiply_tb.sv -----
// ----------------------------------------------------------------------------
// csr spmv testbench
// drives request words into the block with random gaps, takes row results
// with random stalls, and compares every row result, field by field, with a
// cycle-free prediction of the row sums, including saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import spmv_pkg::*;

typedef struct {
   logic [1:0]                mode;
   logic [INDEX_W-1:0]        index;
   logic signed [VALUE_W-1:0] value;
   logic                      last;
} spmv_word_type;

class spmv_row_scoreboard;
   logic [VALUE_W-1:0]      vector_copy [VECTOR_DEPTH];
   logic signed [SUM_W-1:0] acc_sum;
   logic                    acc_sat;
   logic [ROW_W-1:0]        next_row;
   spmv_result_type         expected_rows [$];
   int unsigned             mismatches;

   function new();
      foreach (vector_copy[i]) vector_copy[i] = '0;
      acc_sum    = '0;
      acc_sat    = 1'b0;
      next_row   = '0;
      mismatches = 0;
   endfunction

   function void finish_row();
      spmv_result_type row;
      row.row_index = next_row;
      row.row_sum   = acc_sum;
      row.saturated = acc_sat;
      expected_rows.push_back(row);
      acc_sum  = '0;
      acc_sat  = 1'b0;
      next_row = next_row + 1'b1;
   endfunction

   // one accepted request word
   function void predict_word(spmv_word_type w);
      logic signed [SUM_W-1:0] coef, elem, prod, total;
      case (w.mode)
         MODE_LOAD: vector_copy[w.index] = w.value;
         MODE_NONZERO: begin
            coef  = w.value;
            elem  = $signed(vector_copy[w.index]);
            prod  = coef * elem;
            total = acc_sum + prod;
            // same-sign operands with a sign flip in the sum clamp the row
            if (acc_sum[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != acc_sum[SUM_W-1]) begin
               acc_sum = acc_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
               acc_sat = 1'b1;
            end else begin
               acc_sum = total;
            end
            if (w.last) finish_row();
         end
         MODE_EMPTY: finish_row();
         default: ;
      endcase
   endfunction

   function void report_field(string field, logic signed [SUM_W-1:0] want,
                              logic signed [SUM_W-1:0] got);
      if (mismatches < 100)
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
   endfunction

   function void check_row(spmv_result_type got);
      spmv_result_type want;
      if (expected_rows.size() == 0) begin
         if (mismatches < 100)
            $error("row result with none pending: row_index %0d", got.row_index);
         mismatches++;
         return;
      end
      want = expected_rows.pop_front();
      if (got.row_index !== want.row_index)
         report_field("row_index", want.row_index, got.row_index);
      if (got.row_sum !== want.row_sum)
         report_field("row_sum", want.row_sum, got.row_sum);
      if (got.saturated !== want.saturated)
         report_field("saturated", want.saturated, got.saturated);
   endfunction

   function void finish_check();
      if (expected_rows.size() != 0) begin
         $error("%0d row results never arrived", expected_rows.size());
         mismatches += expected_rows.size();
      end
   endfunction
endclass

module csr_sparse_matrix_vector_multiply_tb;

   localparam logic [1:0] MODE_IGNORED = 2'd3;   // no code in the package, block drops it

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RESET_CYCLES = 10;
   localparam int PHASE_WORDS  = 360;            // four phases, about 1450 words
   localparam int HOLD_CYCLES  = 300;            // long receiver hold-off
   localparam int DRAIN_CYCLES = 12;             // longer than the pipeline latency

   localparam logic [VALUE_W-1:0] NEG_FULL = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] POS_FULL = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] Q_ONE    = 32'h0001_0000;
   localparam logic [VALUE_W-1:0] Q_TWO    = 32'h0002_0000;
   localparam logic [VALUE_W-1:0] Q_M_ONE  = 32'hffff_0000;

   localparam logic [INDEX_W-1:0] COL_LOW  = '0;
   localparam logic [INDEX_W-1:0] COL_HIGH = '1;
   localparam logic [INDEX_W-1:0] COL_ALT1 = 12'haaa;
   localparam logic [INDEX_W-1:0] COL_ALT0 = 12'h555;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spmv_req_if req_chan ();
   spmv_rsp_if rsp_chan ();

   csr_sparse_matrix_vector_multiply uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   spmv_row_scoreboard rows_sb;

   // pacing knobs, set by the stimulus between phases
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request  = 0;   // stimulus asks for a hold-off, receiver counts it down
   int hold_left     = 0;

   int unsigned cycle_count = 0;
   int unsigned words_sent  = 0;   // accepted words that the block acts on

   // columns whose vector element has been loaded, so no read of an unwritten entry
   logic [INDEX_W-1:0] loaded_cols [$];
   bit                 col_loaded [VECTOR_DEPTH];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL csr_sparse_matrix_vector_multiply");
         $finish;
      end
   end

   // both channels are sampled at the rising edge, inputs move at the falling one
   always @(posedge clock) begin
      spmv_word_type   w;
      spmv_result_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            w.mode  = req_chan.mode;
            w.index = req_chan.index;
            w.value = req_chan.value;
            w.last  = req_chan.last_in_row;
            rows_sb.predict_word(w);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.row_index = rsp_chan.row_index;
            got.row_sum   = rsp_chan.row_sum;
            got.saturated = rsp_chan.saturated;
            rows_sb.check_row(got);
         end
      end
   end

   // result side: random stalls, plus a long hold-off counted here on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // entered and left at a falling edge; valid is assigned once per edge
   task automatic send_word(input logic [1:0] mode, input logic [INDEX_W-1:0] index,
                            input logic [VALUE_W-1:0] value, input logic last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         // junk payload while idle, the block must not look at it
         req_chan.valid       <= 1'b0;
         req_chan.mode        <= 2'($urandom);
         req_chan.index       <= INDEX_W'($urandom);
         req_chan.value       <= VALUE_W'($urandom);
         req_chan.last_in_row <= 1'($urandom);
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= mode;
      req_chan.index       <= index;
      req_chan.value       <= value;
      req_chan.last_in_row <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (mode != MODE_IGNORED) words_sent++;
      @(negedge clock);
   endtask

   task automatic load_element(input logic [INDEX_W-1:0] index,
                               input logic [VALUE_W-1:0] value);
      // row-end mark on a load is noise
      send_word(MODE_LOAD, index, value, 1'($urandom));
      if (!col_loaded[index]) begin
         col_loaded[index] = 1'b1;
         loaded_cols.push_back(index);
      end
   endtask

   // sender stops until every pending row result is back
   task automatic wait_rows_drained();
      req_chan.valid <= 1'b0;
      while (rows_sb.expected_rows.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // hot rows lean on the extremes so that sums reach the clamp
   function automatic logic [VALUE_W-1:0] pick_value(input bit hot);
      int roll;
      roll = hot ? $urandom_range(3) : $urandom_range(9);
      case (roll)
         0:       return NEG_FULL;
         1:       return POS_FULL;
         4, 5, 6: return $urandom_range(262143) - 32'd131072;   // within +-2.0
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_col();
      return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
   endfunction

   task automatic send_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // store ends, row-end mark on a load must be ignored
      send_word(MODE_LOAD, COL_LOW, NEG_FULL, 1'b1);
      send_word(MODE_LOAD, COL_HIGH, POS_FULL, 1'b0);
      col_loaded[COL_LOW]  = 1'b1;
      col_loaded[COL_HIGH] = 1'b1;
      loaded_cols.push_back(COL_LOW);
      loaded_cols.push_back(COL_HIGH);
      // two largest positive products clamp at the top
      send_word(MODE_NONZERO, COL_LOW, NEG_FULL, 1'b0);
      send_word(MODE_NONZERO, COL_LOW, NEG_FULL, 1'b1);
      // three large negative products clamp at the bottom, then a positive
      // term leaves the clamp but the flag stays set
      send_word(MODE_NONZERO, COL_HIGH, NEG_FULL, 1'b0);
      send_word(MODE_NONZERO, COL_HIGH, NEG_FULL, 1'b0);
      send_word(MODE_NONZERO, COL_HIGH, NEG_FULL, 1'b0);
      send_word(MODE_NONZERO, COL_LOW, NEG_FULL, 1'b1);
      // empty row with a stray row-end mark
      send_word(MODE_EMPTY, COL_HIGH, POS_FULL, 1'b1);
      // unused mode, all payload bits high
      send_word(MODE_IGNORED, COL_HIGH, '1, 1'b1);
      // load followed at once by a read of the same element
      load_element(COL_ALT1, Q_ONE);
      send_word(MODE_NONZERO, COL_ALT1, Q_TWO, 1'b1);
      // terms left pending, then closed by an empty-row word
      load_element(COL_ALT0, Q_M_ONE);
      send_word(MODE_NONZERO, COL_ALT0, POS_FULL, 1'b0);
      send_word(MODE_EMPTY, COL_ALT0, Q_ONE, 1'b0);
      // zero value, then an overwritten element read back as zero
      send_word(MODE_NONZERO, COL_ALT1, '0, 1'b1);
      load_element(COL_LOW, '0);
      send_word(MODE_NONZERO, COL_LOW, POS_FULL, 1'b1);
      send_word(MODE_NONZERO, COL_HIGH, POS_FULL, 1'b1);
   endtask

   // one random piece: mostly well-formed rows, some loads, noise and broken rows
   task automatic send_random_rows();
      int                 roll;
      int                 terms;
      bit                 hot;
      logic [INDEX_W-1:0] col;
      roll = $urandom_range(99);
      if (roll < 10) begin
         load_element(INDEX_W'($urandom), pick_value(1'b0));
      end else if (roll < 13) begin
         send_word(MODE_IGNORED, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom));
      end else if (roll < 19) begin
         // broken row: no row-end mark, closed by an empty-row word
         terms = $urandom_range(1, 3);
         repeat (terms) send_word(MODE_NONZERO, pick_col(), pick_value(1'b0), 1'b0);
         send_word(MODE_EMPTY, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom));
      end else if (roll < 27) begin
         send_word(MODE_EMPTY, INDEX_W'($urandom), VALUE_W'($urandom), 1'($urandom));
      end else begin
         hot   = ($urandom_range(6) == 0);
         terms = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (int k = 1; k <= terms; k++) begin
            col = pick_col();
            if ($urandom_range(9) == 0) begin
               // fresh element read right after its load
               col = INDEX_W'($urandom);
               load_element(col, pick_value(hot));
            end
            send_word(MODE_NONZERO, col, pick_value(hot), k == terms);
         end
      end
      if ($urandom_range(59) == 0) wait_rows_drained();
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
      int unsigned stop_at;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      // receiver holds off while the sender keeps offering words
      if (long_hold) hold_request = HOLD_CYCLES;
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) send_random_rows();
      wait_rows_drained();
   endtask

   initial begin
      rows_sb = new();
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_LOAD;
      req_chan.index       = '0;
      req_chan.value       = '0;
      req_chan.last_in_row = 1'b0;
      rsp_chan.ready       = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_directed();
      wait_rows_drained();

      run_phase(0, 0, 1'b1);      // no idling, long hold-off at the start
      run_phase(60, 0, 1'b0);     // sender idle
      run_phase(0, 60, 1'b0);     // receiver stalls
      run_phase(31, 31, 1'b1);    // both, another hold-off

      // late or extra results show up as unexpected rows
      repeat (DRAIN_CYCLES) @(posedge clock);
      rows_sb.finish_check();

      if (rows_sb.mismatches == 0) begin
         $display("PASS csr_sparse_matrix_vector_multiply");
      end else begin
         $display("FAIL csr_sparse_matrix_vector_multiply");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/spmv_pkg.sv
design/spmv_if.sv
design/spmv_vec_store.sv
design/spmv_mac.sv
design/csr_sparse_matrix_vector_multiply.sv
sim/csr_sparse_matrix_vector_multiply_tb.sv
